FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the linked-list value engine.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property sampled on the rising clock, off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/llve_pkg.sv
// Package for the linked-list value engine: sizes, codes, payload structs
// and the request/response structs of the node pool. No dependencies.
package llve_pkg;

  localparam int POOL_NODES = 16;
  localparam int VALUE_BITS = 32;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STS_W  = 2;
  localparam int POS_W  = 5;
  localparam int IDX_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int LINK_W = $clog2(POOL_NODES + 1);
  localparam int CNT_W  = $clog2(POOL_NODES + 2);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);
  localparam logic [CNT_W-1:0]  POS_LIMIT = CNT_W'(POOL_NODES);

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_MISS  = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] new_value;
    logic signed [DATA_W-1:0] match_key;
  } in_req_t;

  typedef struct packed {
    logic [STS_W-1:0]         status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } out_rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]      rd_idx;
    logic                  val_we;
    logic [IDX_W-1:0]      val_widx;
    logic [VALUE_BITS-1:0] val_wdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_widx;
    logic [LINK_W-1:0]     link_wdata;
    logic                  use_set;
    logic                  use_clr;
    logic [IDX_W-1:0]      use_idx;
  } pool_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [LINK_W-1:0]     link;
    logic [IDX_W-1:0]      free_idx;
    logic                  full;
    logic                  none_used;
  } pool_rsp_t;

  // Port value to stored width, zero-extended or truncated.
  function automatic logic [VALUE_BITS-1:0] fit_value(input logic [DATA_W-1:0] x);
    logic [VALUE_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i < DATA_W) begin
        r[i] = x[i];
      end
    end
    return r;
  endfunction

  // Stored value to port width.
  function automatic logic [DATA_W-1:0] to_element(input logic [VALUE_BITS-1:0] x);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (i < VALUE_BITS) begin
        r[i] = x[i];
      end
    end
    return r;
  endfunction

endpackage

FILE: src/linked_list_value_engine.sv
// Linked-list value engine: sequencer walking the node pool one node per cycle while it searches or seeks the tail.
// Depends on llve_pkg, llve_pool and assert_macros.svh.
//
// Usage: one request on in_* (cmd, new_value, match_key) gives result items
// on out_* (status, position, element, last). Both channels use valid/ready.
// in_ready is high only while the sequencer is idle; one request is worked at
// a time. Each cycle the sequencer reads one node (value and link) and runs
// it through the single key comparator and position counter.
// Append allocates a node first, then walks to the tail unless the list was
// empty, and gives FULL at once when the pool is full; search, insert and
// delete walk until a key match or the end marker, and an insert with a free
// node then adds a link step; dump alternates between reading a node and
// emitting it. The first result is loaded into the output register in ST_EMIT
// after the walk ends, once that register is free.
// The output register holds a finished result while out_ready is low; a new
// request can be taken meanwhile, and the sequencer waits only when it has a
// next result and the register is still occupied.
// Reset (rst_n low, synchronous) empties the list and frees every node;
// no clearing pass is needed. Undefined commands are taken and give nothing.
`include "assert_macros.svh"
module linked_list_value_engine import llve_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALLOC, ST_TAIL, ST_FIND, ST_INS_LINK, ST_DUMP, ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [VALUE_BITS-1:0] nv_r, nv_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [LINK_W-1:0]     first_r, first_nxt;
  logic [LINK_W-1:0]     cur_r, cur_nxt;
  logic [LINK_W-1:0]     prev_r, prev_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [IDX_W-1:0]      nn_r, nn_nxt;
  logic                  more_r, more_nxt;
  out_rsp_t              res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_rsp_t              out_data_r, out_data_nxt;

  pool_req_t pool_req;
  pool_rsp_t pool_rsp;

  logic cur_null, link_null, key_hit, tail_stop;

  llve_pool u_pool (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pool_req),
    .rsp   (pool_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_null  = (cur_r >= NULL_LINK);
  assign link_null = (pool_rsp.link >= NULL_LINK);
  assign key_hit   = (pool_rsp.value == key_r);
  assign tail_stop = link_null || (pos_r >= POS_LIMIT);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    nv_nxt        = nv_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    nn_nxt        = nn_r;
    more_nxt      = more_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    pool_req        = '0;
    pool_req.rd_idx = cur_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.cmd;
          nv_nxt   = fit_value(in_data.new_value);
          key_nxt  = fit_value(in_data.match_key);
          cur_nxt  = first_r;
          prev_nxt = NULL_LINK;
          pos_nxt  = CNT_W'(1);
          more_nxt = 1'b0;
          res_nxt  = '{status: STS_OK, position: '0, element: '0, last: 1'b1};
          case (in_data.cmd)
            CMD_APPEND: state_nxt = ST_ALLOC;
            CMD_SEARCH, CMD_INSERT, CMD_DELETE: state_nxt = ST_FIND;
            CMD_DUMP: begin
              if (first_r >= NULL_LINK) begin
                res_nxt.status = STS_EMPTY;
                state_nxt      = ST_EMIT;
              end else begin
                state_nxt = ST_DUMP;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_ALLOC: begin
        if (pool_rsp.full) begin
          res_nxt.status = STS_FULL;
          state_nxt      = ST_EMIT;
        end else begin
          pool_req.val_we     = 1'b1;
          pool_req.val_widx   = pool_rsp.free_idx;
          pool_req.val_wdata  = nv_r;
          pool_req.link_we    = 1'b1;
          pool_req.link_widx  = pool_rsp.free_idx;
          pool_req.link_wdata = NULL_LINK;
          pool_req.use_set    = 1'b1;
          pool_req.use_idx    = pool_rsp.free_idx;
          nn_nxt              = pool_rsp.free_idx;
          if (first_r >= NULL_LINK) begin
            first_nxt = LINK_W'(pool_rsp.free_idx);
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_TAIL;
          end
        end
      end

      ST_TAIL: begin
        if (tail_stop) begin
          pool_req.link_we    = 1'b1;
          pool_req.link_widx  = cur_r[IDX_W-1:0];
          pool_req.link_wdata = LINK_W'(nn_r);
          state_nxt           = ST_EMIT;
        end else begin
          cur_nxt = pool_rsp.link;
          pos_nxt = pos_r + 1'b1;
        end
      end

      ST_FIND: begin
        if (cur_null || (pos_r > POS_LIMIT)) begin
          res_nxt.status = STS_MISS;
          state_nxt      = ST_EMIT;
        end else if (key_hit) begin
          res_nxt.position = POS_W'(pos_r);
          res_nxt.element  = to_element(pool_rsp.value);
          state_nxt        = ST_EMIT;
          case (cmd_r)
            CMD_INSERT: begin
              if (pool_rsp.full) begin
                res_nxt = '{status: STS_FULL, position: '0, element: '0, last: 1'b1};
              end else begin
                pool_req.val_we     = 1'b1;
                pool_req.val_widx   = pool_rsp.free_idx;
                pool_req.val_wdata  = nv_r;
                pool_req.link_we    = 1'b1;
                pool_req.link_widx  = pool_rsp.free_idx;
                pool_req.link_wdata = pool_rsp.link;
                pool_req.use_set    = 1'b1;
                pool_req.use_idx    = pool_rsp.free_idx;
                nn_nxt              = pool_rsp.free_idx;
                state_nxt           = ST_INS_LINK;
              end
            end
            CMD_DELETE: begin
              if (prev_r >= NULL_LINK) begin
                first_nxt = pool_rsp.link;
              end else begin
                pool_req.link_we    = 1'b1;
                pool_req.link_widx  = prev_r[IDX_W-1:0];
                pool_req.link_wdata = pool_rsp.link;
              end
              pool_req.use_clr = 1'b1;
              pool_req.use_idx = cur_r[IDX_W-1:0];
            end
            default: ;
          endcase
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = pool_rsp.link;
          pos_nxt  = pos_r + 1'b1;
        end
      end

      ST_INS_LINK: begin
        pool_req.link_we    = 1'b1;
        pool_req.link_widx  = cur_r[IDX_W-1:0];
        pool_req.link_wdata = LINK_W'(nn_r);
        state_nxt           = ST_EMIT;
      end

      ST_DUMP: begin
        res_nxt.status   = STS_OK;
        res_nxt.position = POS_W'(pos_r);
        res_nxt.element  = to_element(pool_rsp.value);
        res_nxt.last     = tail_stop;
        more_nxt         = !tail_stop;
        cur_nxt          = pool_rsp.link;
        pos_nxt          = pos_r + 1'b1;
        state_nxt        = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = more_r ? ST_DUMP : ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= NULL_LINK;
      out_valid_r <= 1'b0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      more_r      <= more_nxt;
    end
    cmd_r      <= cmd_nxt;
    nv_r       <= nv_nxt;
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    pos_r      <= pos_nxt;
    nn_r       <= nn_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_IMPL(a_alloc_not_full, clk, rst_n, pool_req.use_set, !pool_rsp.full, "alloc from full pool")
  `ASSERT_IMPL(a_empty_head, clk, rst_n, (state_r == ST_IDLE) && (first_r == NULL_LINK), pool_rsp.none_used, "empty list with nodes in use")
  `ASSERT_IMPL(a_mid_result, clk, rst_n, out_valid_r && !out_data_r.last, (out_data_r.status == STS_OK) && (out_data_r.position != '0), "bad non-final result")
  `ASSERT_IMPL(a_empty_result, clk, rst_n, out_valid_r && (out_data_r.status == STS_EMPTY), out_data_r.last && (out_data_r.position == '0) && (out_data_r.element == '0), "bad empty-list result")

endmodule

FILE: src/llve_pool.sv
// Node pool: value and link register files, in-use map and lowest-free finder.
// Depends on llve_pkg.
module llve_pool import llve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pool_req_t req,
  output pool_rsp_t rsp
);

  logic [VALUE_BITS-1:0] values_r [POOL_NODES];
  logic [LINK_W-1:0]     links_r  [POOL_NODES];
  logic [POOL_NODES-1:0] in_use_r;
  logic [IDX_W-1:0]      free_idx;

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      values_r[req.val_widx] <= req.val_wdata;
    end
    if (req.link_we) begin
      links_r[req.link_widx] <= req.link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (req.use_set) begin
      in_use_r[req.use_idx] <= 1'b1;
    end else if (req.use_clr) begin
      in_use_r[req.use_idx] <= 1'b0;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = POOL_NODES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rsp.value     = values_r[req.rd_idx];
    rsp.link      = links_r[req.rd_idx];
    rsp.free_idx  = free_idx;
    rsp.full      = &in_use_r;
    rsp.none_used = ~|in_use_r;
  end

endmodule
